// ----- hw/rtl/qsel_pkg.sv -----
package qsel_pkg;

   // Store depth, and the widths that follow from it
   localparam int MAX_ITEMS = 1024;
   localparam int INDEX_W   = $clog2(MAX_ITEMS);
   localparam int COUNT_W   = $clog2(MAX_ITEMS + 1);

   // Fixed field widths
   localparam int SAMPLE_W = 32;
   localparam int RANK_W   = 10;

   // Quantile fraction, unsigned Q1.16
   localparam int Q_W    = 17;
   localparam int Q_FRAC = 16;
   localparam logic [Q_W-1:0] Q_ONE   = Q_W'(65536);
   localparam logic [Q_W-1:0] Q_RESET = Q_W'(32768);

   // count * q and its integer part
   localparam int PROD_W = COUNT_W + Q_W;
   localparam int POS_W  = PROD_W - Q_FRAC;

   localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(MAX_ITEMS);

   // Per-cycle command to every cell of the chain
   typedef struct packed {
      logic load;   // insert the new sample in sorted place
      logic shift;  // move every value one cell toward the head
   } qsel_chain_ctl_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_MULT,
      ST_POS,
      ST_SHIFT,
      ST_DONE
   } qsel_state_type;

endpackage

// ----- hw/rtl/qsel_cell.sv -----
module qsel_cell (
   input  logic                                 clock,
   input  qsel_pkg::qsel_chain_ctl_type         chain_ctl,
   input  logic [qsel_pkg::INDEX_W-1:0]         cell_index,
   input  logic [qsel_pkg::COUNT_W-1:0]         fill_count,
   input  logic signed [qsel_pkg::SAMPLE_W-1:0] new_sample,
   input  logic signed [qsel_pkg::SAMPLE_W-1:0] left_value,
   input  logic                                 left_displace,
   input  logic signed [qsel_pkg::SAMPLE_W-1:0] right_value,
   output logic signed [qsel_pkg::SAMPLE_W-1:0] value,
   output logic                                 displace
);

   logic signed [qsel_pkg::SAMPLE_W-1:0] value_ff;
   logic signed [qsel_pkg::SAMPLE_W-1:0] value_in;
   logic                                 live;

   // Cell holds a sample only while it lies below the fill count
   assign live = fill_count > qsel_pkg::COUNT_W'(cell_index);

   // New sample sorts ahead of this cell's value (equal values stay ahead)
   assign displace = !live || (new_sample < value_ff);

   // Insert: first displaced cell takes the new sample, the rest take the left value
   always_comb begin
      value_in = value_ff;
      if (chain_ctl.shift) begin
         value_in = right_value;
      end else if (chain_ctl.load && displace) begin
         value_in = left_displace ? left_value : new_sample;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

// ----- hw/rtl/qsel_ctrl.sv -----
module qsel_ctrl (
   input  logic                                 clock,
   input  logic                                 reset,
   // input beats
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_last,
   // result beats
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [qsel_pkg::SAMPLE_W-1:0] rsp_quantile_value,
   output logic [qsel_pkg::RANK_W-1:0]          rsp_rank,
   output logic                                 rsp_overflow,
   // register write
   input  logic                                 csr_wr_en,
   input  logic [qsel_pkg::Q_W-1:0]             csr_wr_data,
   // chain
   output qsel_pkg::qsel_chain_ctl_type         chain_ctl,
   output logic [qsel_pkg::COUNT_W-1:0]         fill_count,
   input  logic signed [qsel_pkg::SAMPLE_W-1:0] head_value
);

   qsel_pkg::qsel_state_type state_ff, state_in;

   logic [qsel_pkg::Q_W-1:0]     q_ff, q_in;
   logic [qsel_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                         ovf_ff, ovf_in;
   logic [qsel_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic [qsel_pkg::INDEX_W-1:0] pos_ff, pos_in;
   logic [qsel_pkg::INDEX_W-1:0] shift_cnt_ff, shift_cnt_in;

   logic                                 rsp_valid_ff, rsp_valid_in;
   logic signed [qsel_pkg::SAMPLE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [qsel_pkg::RANK_W-1:0]          rsp_rank_ff, rsp_rank_in;
   logic                                 rsp_ovf_ff, rsp_ovf_in;

   logic                         accept;
   logic                         store;
   logic                         out_free;
   logic                         finish;
   logic [qsel_pkg::Q_W-1:0]     q_sat;
   logic [qsel_pkg::POS_W-1:0]   pos_raw;
   logic [qsel_pkg::COUNT_W-1:0] pos_clamped;

   assign accept   = req_valid && req_ready;
   assign store    = accept && (count_ff != qsel_pkg::COUNT_FULL);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign finish   = (state_ff == qsel_pkg::ST_DONE) && out_free;

   // Fraction above one selects the largest sample
   assign q_sat = (q_ff > qsel_pkg::Q_ONE) ? qsel_pkg::Q_ONE : q_ff;

   // Rank = floor(count * q), clamped below count
   assign pos_raw     = prod_ff[qsel_pkg::PROD_W-1:qsel_pkg::Q_FRAC];
   assign pos_clamped = (pos_raw >= qsel_pkg::POS_W'(count_ff))
                      ? count_ff - qsel_pkg::COUNT_W'(1)
                      : qsel_pkg::COUNT_W'(pos_raw);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         qsel_pkg::ST_LOAD: begin
            if (accept && req_last) begin
               state_in = qsel_pkg::ST_MULT;
            end
         end
         qsel_pkg::ST_MULT:  state_in = qsel_pkg::ST_POS;
         qsel_pkg::ST_POS:   state_in = qsel_pkg::ST_SHIFT;
         qsel_pkg::ST_SHIFT: begin
            if (shift_cnt_ff == '0) begin
               state_in = qsel_pkg::ST_DONE;
            end
         end
         qsel_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = qsel_pkg::ST_LOAD;
            end
         end
         default: state_in = qsel_pkg::ST_LOAD;
      endcase
   end

   // Outputs of the state machine
   always_comb begin
      req_ready       = 1'b0;
      chain_ctl.load  = 1'b0;
      chain_ctl.shift = 1'b0;
      unique case (state_ff)
         qsel_pkg::ST_LOAD: begin
            req_ready      = 1'b1;
            chain_ctl.load = store;
         end
         qsel_pkg::ST_SHIFT: chain_ctl.shift = (shift_cnt_ff != '0);
         qsel_pkg::ST_MULT,
         qsel_pkg::ST_POS,
         qsel_pkg::ST_DONE: begin
            req_ready = 1'b0;
         end
         default: req_ready = 1'b0;
      endcase
   end

   // Datapath registers
   always_comb begin
      q_in         = csr_wr_en ? csr_wr_data : q_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      prod_in      = prod_ff;
      pos_in       = pos_ff;
      shift_cnt_in = shift_cnt_ff;

      // fill count and overflow flag of the open set
      if (store) begin
         count_in = count_ff + qsel_pkg::COUNT_W'(1);
      end else if (accept) begin
         ovf_in = 1'b1;
      end
      if (finish) begin
         count_in = '0;
         ovf_in   = 1'b0;
      end

      if (state_ff == qsel_pkg::ST_MULT) begin
         prod_in = qsel_pkg::PROD_W'(count_ff) * qsel_pkg::PROD_W'(q_sat);
      end
      if (state_ff == qsel_pkg::ST_POS) begin
         pos_in       = pos_clamped[qsel_pkg::INDEX_W-1:0];
         shift_cnt_in = pos_clamped[qsel_pkg::INDEX_W-1:0];
      end
      if (chain_ctl.shift) begin
         shift_cnt_in = shift_cnt_ff - qsel_pkg::INDEX_W'(1);
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      rsp_rank_in  = rsp_rank_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = head_value;
         rsp_rank_in  = qsel_pkg::RANK_W'(pos_ff);
         rsp_ovf_in   = ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= qsel_pkg::ST_LOAD;
         q_ff         <= qsel_pkg::Q_RESET;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         shift_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         q_ff         <= q_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         shift_cnt_ff <= shift_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff      <= prod_in;
      pos_ff       <= pos_in;
      rsp_value_ff <= rsp_value_in;
      rsp_rank_ff  <= rsp_rank_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign fill_count         = count_ff;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_quantile_value = rsp_value_ff;
   assign rsp_rank           = rsp_rank_ff;
   assign rsp_overflow       = rsp_ovf_ff;

   // Chain never inserts and shifts in the same cycle
   a_load_shift_excl: assert property (@(posedge clock) disable iff (reset)
      !(chain_ctl.load && chain_ctl.shift))
      else $error("chain load and shift together");

   // Fill count stays within the store
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= qsel_pkg::COUNT_FULL)
      else $error("fill count beyond store depth");

   // Selected rank lies inside the closed set
   a_rank_in_set: assert property (@(posedge clock) disable iff (reset)
      state_ff == qsel_pkg::ST_SHIFT |-> qsel_pkg::COUNT_W'(pos_ff) < count_ff)
      else $error("selected rank outside the set");

   // A result beat appears only when a selection completes
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == qsel_pkg::ST_DONE))
      else $error("result beat without a finished selection");

endmodule

// ----- hw/rtl/quantile_select.sv -----
// quantile_select: k-th smallest selection over a set of up to MAX_ITEMS (1024)
// signed 32-bit samples. Samples are taken one per cycle while req_ready is high and
// inserted in sorted order into a chain of 1024 cells; the beat with req_last closes
// the set (samples past a full store are dropped and flagged by rsp_overflow). The
// block then computes rank = floor(count * q), q = csr fraction in Q1.16 saturated
// at 1.0 and the rank clamped to count-1, and shifts the chain toward the head
// rank times; req_ready stays low from the closing beat until the result beat is
// registered. The cost of the selection is set by the one-cell-per-cycle shift
// of the chain. No clearing pass is needed after reset; csr writes are taken at
// any time and apply to the next set closed.
module quantile_select (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [qsel_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                 req_last,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [qsel_pkg::SAMPLE_W-1:0] rsp_quantile_value,
   output logic [qsel_pkg::RANK_W-1:0]          rsp_rank,
   output logic                                 rsp_overflow,
   input  logic                                 csr_wr_en,
   input  logic [qsel_pkg::Q_W-1:0]             csr_wr_data
);

   qsel_pkg::qsel_chain_ctl_type         chain_ctl;
   logic [qsel_pkg::COUNT_W-1:0]         fill_count;
   logic signed [qsel_pkg::SAMPLE_W-1:0] cell_value   [qsel_pkg::MAX_ITEMS];
   logic                                 cell_displace[qsel_pkg::MAX_ITEMS];
   logic signed [qsel_pkg::SAMPLE_W-1:0] left_value   [qsel_pkg::MAX_ITEMS];
   logic                                 left_displace[qsel_pkg::MAX_ITEMS];
   logic signed [qsel_pkg::SAMPLE_W-1:0] right_value  [qsel_pkg::MAX_ITEMS];

   qsel_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_last           (req_last),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_quantile_value (rsp_quantile_value),
      .rsp_rank           (rsp_rank),
      .rsp_overflow       (rsp_overflow),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .chain_ctl          (chain_ctl),
      .fill_count         (fill_count),
      .head_value         (cell_value[0])
   );

   // Sorted chain, head (smallest) at cell 0
   for (genvar g = 0; g < qsel_pkg::MAX_ITEMS; g++) begin : g_cell
      if (g == 0) begin : g_head
         assign left_value[g]    = '0;
         assign left_displace[g] = 1'b0;
      end else begin : g_body
         assign left_value[g]    = cell_value[g-1];
         assign left_displace[g] = cell_displace[g-1];
      end
      if (g == qsel_pkg::MAX_ITEMS - 1) begin : g_tail
         assign right_value[g] = cell_value[g];
      end else begin : g_inner
         assign right_value[g] = cell_value[g+1];
      end

      qsel_cell u_cell (
         .clock         (clock),
         .chain_ctl     (chain_ctl),
         .cell_index    (qsel_pkg::INDEX_W'(g)),
         .fill_count    (fill_count),
         .new_sample    (req_sample),
         .left_value    (left_value[g]),
         .left_displace (left_displace[g]),
         .right_value   (right_value[g]),
         .value         (cell_value[g]),
         .displace      (cell_displace[g])
      );
   end

endmodule

// ----- tb/quantile_select_tb.sv -----
`timescale 1ns / 1ps

module quantile_select_tb;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int RANDOM_ITEMS = 650;

   // One result beat, field by field
   typedef struct packed {
      logic signed [qsel_pkg::SAMPLE_W-1:0] quantile_value;
      logic [qsel_pkg::RANK_W-1:0]          rank;
      logic                                 overflow;
   } quantile_result_type;

   // One row of the directed table
   typedef struct packed {
      logic                                 set_fraction;
      logic [qsel_pkg::Q_W-1:0]             fraction;
      logic signed [qsel_pkg::SAMPLE_W-1:0] sample;
      logic                                 last;
      logic                                 typed;
      quantile_result_type                  result;
   } stim_row_type;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_ready;
   logic signed [qsel_pkg::SAMPLE_W-1:0] req_sample = '0;
   logic                                 req_last = 1'b0;
   logic                                 rsp_valid;
   logic                                 rsp_ready = 1'b0;
   logic signed [qsel_pkg::SAMPLE_W-1:0] rsp_quantile_value;
   logic [qsel_pkg::RANK_W-1:0]          rsp_rank;
   logic                                 rsp_overflow;
   logic                                 csr_wr_en = 1'b0;
   logic [qsel_pkg::Q_W-1:0]             csr_wr_data = '0;

   quantile_select dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_sample         (req_sample),
      .req_last           (req_last),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_quantile_value (rsp_quantile_value),
      .rsp_rank           (rsp_rank),
      .rsp_overflow       (rsp_overflow),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   always #5 clock = ~clock;

   // Predictor state: samples of the open set kept in ascending order
   logic signed [qsel_pkg::SAMPLE_W-1:0] sorted_samples [0:qsel_pkg::MAX_ITEMS-1];
   int unsigned                          held_count = 0;
   bit                                   dropped_seen = 1'b0;
   logic [qsel_pkg::Q_W-1:0]             fraction_reg = qsel_pkg::Q_RESET;

   quantile_result_type pending_quantiles [$];
   stim_row_type        directed_rows [$];
   int                  error_count = 0;
   int                  beats_sent = 0;
   int                  burst_left = 0;
   int                  cycle_count = 0;
   int                  stall_mode = 0;

   // Insert one sample; on the closing beat pick the quantile and clear the set
   task automatic absorb_sample(input logic signed [qsel_pkg::SAMPLE_W-1:0] s,
                                input logic l,
                                output bit closes, output quantile_result_type r);
      int unsigned              slot;
      int unsigned              pos;
      longint unsigned          product;
      logic [qsel_pkg::Q_W-1:0] q_sat;
      if (held_count < qsel_pkg::MAX_ITEMS) begin
         slot = held_count;
         while (slot > 0 && sorted_samples[slot-1] > s) begin
            sorted_samples[slot] = sorted_samples[slot-1];
            slot--;
         end
         sorted_samples[slot] = s;
         held_count++;
      end else begin
         dropped_seen = 1'b1;
      end
      closes = l;
      r = '0;
      if (l) begin
         q_sat = (fraction_reg > qsel_pkg::Q_ONE) ? qsel_pkg::Q_ONE : fraction_reg;
         product = longint'(held_count) * longint'(q_sat);
         pos = int'(product >> qsel_pkg::Q_FRAC);
         if (pos >= held_count) pos = held_count - 1;
         r.quantile_value = sorted_samples[pos];
         r.rank = qsel_pkg::RANK_W'(pos);
         r.overflow = dropped_seen;
         held_count = 0;
         dropped_seen = 1'b0;
      end
   endtask

   // Drive one beat, in bursts with random gaps; predict on acceptance
   task automatic send_beat(input logic signed [qsel_pkg::SAMPLE_W-1:0] s, input logic l,
                            input logic typed, input quantile_result_type typed_res);
      int                  gap;
      bit                  closes;
      quantile_result_type predicted;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 3);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 48);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      req_last   <= l;
      do @(posedge clock); while (!req_ready);
      burst_left--;
      beats_sent++;
      absorb_sample(s, l, closes, predicted);
      if (closes) pending_quantiles.push_back(typed ? typed_res : predicted);
   endtask

   // Let the block go idle: every result in, then a few spare cycles
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_quantiles.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_fraction(input logic [qsel_pkg::Q_W-1:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      fraction_reg = v;
   endtask

   task automatic add_row(input logic set_fraction, input logic [qsel_pkg::Q_W-1:0] fraction,
                          input logic signed [qsel_pkg::SAMPLE_W-1:0] sample,
                          input logic last, input logic typed,
                          input logic signed [qsel_pkg::SAMPLE_W-1:0] exp_value,
                          input int exp_rank);
      stim_row_type row;
      row.set_fraction          = set_fraction;
      row.fraction              = fraction;
      row.sample                = sample;
      row.last                  = last;
      row.typed                 = typed;
      row.result.quantile_value = exp_value;
      row.result.rank           = qsel_pkg::RANK_W'(exp_rank);
      row.result.overflow       = 1'b0;
      directed_rows.push_back(row);
   endtask

   // Mix of full-range values, extremes and a narrow band that forces ties
   function automatic logic signed [qsel_pkg::SAMPLE_W-1:0] pick_sample();
      int narrow;
      narrow = $urandom_range(0, 16);
      case ($urandom_range(0, 9))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7fff_ffff;
         2, 3:    return narrow - 8;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [qsel_pkg::Q_W-1:0] pick_fraction();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return qsel_pkg::Q_ONE;
         2:       return qsel_pkg::Q_ONE + qsel_pkg::Q_W'($urandom_range(1, 65535));
         3:       return qsel_pkg::Q_RESET;
         default: return qsel_pkg::Q_W'($urandom_range(0, 65536));
      endcase
   endfunction

   // Closes a set of n samples; n past the store depth drops the tail
   task automatic send_set(input int n);
      for (int i = 0; i < n; i++) send_beat(pick_sample(), i == n - 1, 1'b0, '0);
   endtask

   // Receiver stall pattern: free running, light stalls or long stalls
   always @(posedge clock) begin
      if (cycle_count % 200 == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= ($urandom_range(0, 9) < 7);
         default: rsp_ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   // Result check against the oldest expectation
   always @(posedge clock) begin
      quantile_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_quantiles.size() == 0) begin
            $error("unexpected result beat: value %0d rank %0d overflow %0b",
                   rsp_quantile_value, rsp_rank, rsp_overflow);
            error_count++;
         end else begin
            want = pending_quantiles.pop_front();
            if (rsp_quantile_value !== want.quantile_value) begin
               $error("quantile_value: expected %0d, got %0d",
                      want.quantile_value, rsp_quantile_value);
               error_count++;
            end
            if (rsp_rank !== want.rank) begin
               $error("rank: expected %0d, got %0d", want.rank, rsp_rank);
               error_count++;
            end
            if (rsp_overflow !== want.overflow) begin
               $error("overflow: expected %0b, got %0b", want.overflow, rsp_overflow);
               error_count++;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      // Single samples at the reset fraction: the sample itself, rank 0
      add_row(1'b0, '0, 32'sh8000_0000, 1'b1, 1'b1, 32'sh8000_0000, 0);
      add_row(1'b0, '0, 32'sh7fff_ffff, 1'b1, 1'b1, 32'sh7fff_ffff, 0);
      // q = 0 picks the minimum
      add_row(1'b1, '0, 5, 1'b0, 1'b0, 0, 0);
      add_row(1'b0, '0, -3, 1'b0, 1'b0, 0, 0);
      add_row(1'b0, '0, 7, 1'b1, 1'b1, -3, 0);
      // q = 1.0 clamps to the last rank
      add_row(1'b1, qsel_pkg::Q_ONE, 5, 1'b0, 1'b0, 0, 0);
      add_row(1'b0, '0, -3, 1'b0, 1'b0, 0, 0);
      add_row(1'b0, '0, 7, 1'b0, 1'b0, 0, 0);
      add_row(1'b0, '0, 7, 1'b1, 1'b1, 7, 3);
      // Fraction above one saturates: largest sample
      add_row(1'b1, 17'h1_ffff, 32'sh7fff_ffff, 1'b0, 1'b0, 0, 0);
      add_row(1'b0, '0, -1, 1'b0, 1'b0, 0, 0);
      add_row(1'b0, '0, 32'sh8000_0000, 1'b1, 1'b1, 32'sh7fff_ffff, 2);
      // All samples equal
      add_row(1'b1, qsel_pkg::Q_RESET, 4, 1'b0, 1'b0, 0, 0);
      add_row(1'b0, '0, 4, 1'b0, 1'b0, 0, 0);
      add_row(1'b0, '0, 4, 1'b0, 1'b0, 0, 0);
      add_row(1'b0, '0, 4, 1'b1, 1'b1, 4, 2);
      // Lower quartile over mixed signs
      add_row(1'b1, 17'd16384, 10, 1'b0, 1'b0, 0, 0);
      add_row(1'b0, '0, -10, 1'b0, 1'b0, 0, 0);
      add_row(1'b0, '0, 0, 1'b0, 1'b0, 0, 0);
      add_row(1'b0, '0, 3, 1'b0, 1'b0, 0, 0);
      add_row(1'b0, '0, -2, 1'b1, 1'b0, 0, 0);
      // Smallest nonzero fraction
      add_row(1'b1, 17'd1, 1, 1'b0, 1'b0, 0, 0);
      add_row(1'b0, '0, 2, 1'b1, 1'b0, 0, 0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table
      foreach (directed_rows[i]) begin
         if (directed_rows[i].set_fraction) begin
            settle();
            write_fraction(directed_rows[i].fraction);
         end
         send_beat(directed_rows[i].sample, directed_rows[i].last,
                   directed_rows[i].typed, directed_rows[i].result);
      end

      // Random sets, mostly short, with a new fraction every few sets
      beats_sent = 0;
      while (beats_sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 2) == 0) begin
            settle();
            write_fraction(pick_fraction());
         end
         send_set(($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : $urandom_range(1, 40));
      end

      // Full store at q = 1.0: top rank
      settle();
      write_fraction(qsel_pkg::Q_ONE);
      send_set(qsel_pkg::MAX_ITEMS);

      // Overfull set: tail dropped, closing sample among the dropped
      settle();
      write_fraction(pick_fraction());
      send_set(qsel_pkg::MAX_ITEMS + $urandom_range(1, 6));

      // Drain, idle, then report the result
      settle();
      repeat (1100) @(posedge clock);
      if (error_count == 0 && pending_quantiles.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ----- quantile_select.f -----
hw/rtl/qsel_pkg.sv
hw/rtl/qsel_cell.sv
hw/rtl/qsel_ctrl.sv
hw/rtl/quantile_select.sv
tb/quantile_select_tb.sv
